>>> src/tkf_pkg.sv
// shared constants, types and the atan table for the tilt filter
package tkf_pkg;

  localparam logic [1:0] OP_CALIBRATE = 2'd0;
  localparam logic [1:0] OP_SEED      = 2'd1;
  localparam logic [1:0] OP_FILTER    = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  localparam logic CFG_PROCESS_NOISE     = 1'b0;
  localparam logic CFG_MEASUREMENT_NOISE = 1'b1;

  localparam int CORDIC_ITERS = 24;
  localparam int XYW = 40;  // cordic x/y width
  localparam int ZW  = 32;  // cordic angle width, q.24
  localparam int QW  = 36;  // internal q.24 angle width
  localparam int MA  = 48;  // multiplicand width
  localparam int MB  = 24;  // multiplier width
  localparam int MP  = 72;  // product width

  localparam logic signed [ZW-1:0] PI_Q24     = 32'sd52707179;
  localparam logic [MB-1:0]        GYRO_SCALE = 24'd1257641;
  localparam logic signed [MP-1:0] RND48      = {{(MP-48){1'b0}}, 1'b1, 47'b0};

  typedef logic signed [QW-1:0]  q24_t;
  typedef logic signed [XYW-1:0] cxy_t;

  function automatic logic [23:0] atan_lookup(input logic [4:0] i);
    logic [23:0] v;
    begin
      unique case (i)
        5'd0:  v = 24'd13176795;
        5'd1:  v = 24'd7778716;
        5'd2:  v = 24'd4110060;
        5'd3:  v = 24'd2086331;
        5'd4:  v = 24'd1047214;
        5'd5:  v = 24'd524117;
        5'd6:  v = 24'd262123;
        5'd7:  v = 24'd131069;
        5'd8:  v = 24'd65536;
        5'd9:  v = 24'd32768;
        5'd10: v = 24'd16384;
        5'd11: v = 24'd8192;
        5'd12: v = 24'd4096;
        5'd13: v = 24'd2048;
        5'd14: v = 24'd1024;
        5'd15: v = 24'd512;
        5'd16: v = 24'd256;
        5'd17: v = 24'd128;
        5'd18: v = 24'd64;
        5'd19: v = 24'd32;
        5'd20: v = 24'd16;
        5'd21: v = 24'd8;
        5'd22: v = 24'd4;
        5'd23: v = 24'd2;
        default: v = 24'd0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> src/tkf_mul.sv
// serial shift-add multiplier, one multiplier bit per cycle
module tkf_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [tkf_pkg::MA-1:0] a,
  input  logic [tkf_pkg::MB-1:0]        b,
  output logic                          done,
  output logic signed [tkf_pkg::MP-1:0] p
);
  import tkf_pkg::*;

  localparam int MCW = $clog2(MB);

  logic                 busy_r;
  logic                 done_r;
  logic [MCW-1:0]       cnt_r;
  logic signed [MP-1:0] mcand_r;
  logic [MB-1:0]        mplier_r;
  logic signed [MP-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MCW'(MB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= MP'(a);
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

>>> src/tkf_div.sv
// restoring divider, 32-bit dividend by 17-bit divisor, one quotient bit per cycle
module tkf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [31:0] quo
);
  import tkf_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [16:0] rem_r;
  logic [16:0] den_r;
  logic [31:0] n_r;
  logic [17:0] trial;
  logic        fits;

  assign trial = {rem_r, n_r[31]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      n_r   <= num;
    end else if (busy_r) begin
      rem_r <= fits ? 17'(trial - {1'b0, den_r}) : trial[16:0];
      n_r   <= {n_r[30:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = n_r;

endmodule

>>> src/tkf_sqrt.sv
// bitwise integer square root of s * 2^32, one result bit per cycle
module tkf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] s,
  output logic        done,
  output logic [31:0] root
);
  import tkf_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] n_r;
  logic [63:0] r_r;
  logic [63:0] b_r;
  logic [63:0] rb;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= {s, 32'b0};
      r_r <= '0;
      b_r <= {2'b01, 62'b0};
    end else if (busy_r) begin
      if (n_r >= rb) begin
        n_r <= n_r - rb;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

>>> src/tkf_cordic.sv
// vectoring cordic atan2 in q.24, one rotation per cycle
module tkf_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [tkf_pkg::XYW-1:0] y0,
  input  logic signed [tkf_pkg::XYW-1:0] x0,
  output logic                          done,
  output logic signed [tkf_pkg::ZW-1:0]  z
);
  import tkf_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [4:0]            cnt_r;
  logic signed [XYW-1:0] x_r;
  logic signed [XYW-1:0] y_r;
  logic signed [ZW-1:0]  z_r;
  logic signed [XYW-1:0] xs;
  logic signed [XYW-1:0] ys;
  logic signed [ZW-1:0]  step;
  logic                  both_zero;

  assign xs        = x_r >>> cnt_r;
  assign ys        = y_r >>> cnt_r;
  assign step      = signed'({8'b0, atan_lookup(cnt_r)});
  assign both_zero = (x0 == '0) && (y0 == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        // zero vector answers at once
        if (both_zero) done_r <= 1'b1;
        else           busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'(CORDIC_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (both_zero) begin
        z_r <= '0;
      end else if (x0[XYW-1]) begin
        // left half plane: rotate by pi first
        z_r <= y0[XYW-1] ? -PI_Q24 : PI_Q24;
        x_r <= -x0;
        y_r <= -y0;
      end else begin
        z_r <= '0;
        x_r <= x0;
        y_r <= y0;
      end
    end else if (busy_r) begin
      if (!y_r[XYW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + step;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - step;
      end
    end
  end

  assign done = done_r;
  assign z    = z_r;

endmodule

>>> src/tilt_kalman_filter.sv
// tilt kalman filter top: sequencer, state and shared arithmetic units
//
//  channel | dir | beat contents
//  in_     | in  | tuser: operation; tdata: accel x,y,z, gyro x,y, elapsed ticks
//  out_    | out | tuser: calibrated; tdata: roll, pitch, filter gain
//  cfg_    | in  | index 0 process noise, index 1 measurement noise
//
// calibrate and unused codes go straight to the result stage; a seed and a filter
// step use the shared units in turn: the serial multiplier, the 32-step divider
// and root and the 24-rotation cordic.
// in_tready is high only while the sequencer is idle; a held result stalls the
// next beat's result stage until it is taken. reset is synchronous and returns the defaults.
module tilt_kalman_filter #(
  parameter int CALIB_SAMPLES = 20,
  parameter int ANGLE_WIDTH   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // operation
  input  logic [103:0] in_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ticks
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,  // calibrated
  output logic [47:0]  out_tdata,  // roll_angle, pitch_angle, filter_gain
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import tkf_pkg::*;

  localparam int AW   = ANGLE_WIDTH;
  localparam int SH   = 27 - AW;
  localparam int CW   = $clog2(CALIB_SAMPLES + 1);
  localparam int OSR  = (AW >= 16) ? AW - 16 : 0;
  localparam int OSL  = (AW >= 16) ? 0 : 16 - AW;
  localparam q24_t HALF = q24_t'(1) <<< (SH - 1);
  localparam q24_t AMAX = (q24_t'(1) <<< (AW - 1)) - q24_t'(1);
  localparam q24_t AMIN = -AMAX - q24_t'(1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_BX  = 5'd1,  S_BY   = 5'd2,  S_MR  = 5'd3;
  localparam logic [4:0] S_SQA  = 5'd4,  S_SQB = 5'd5,  S_SQRT = 5'd6,  S_MP  = 5'd7;
  localparam logic [4:0] S_SEED = 5'd8,  S_GR1 = 5'd9,  S_GR2  = 5'd10, S_GP1 = 5'd11;
  localparam logic [4:0] S_GP2  = 5'd12, S_KDV = 5'd13, S_UR   = 5'd14, S_UP  = 5'd15;
  localparam logic [4:0] S_UV   = 5'd16, S_OUT = 5'd17;

  function automatic logic signed [AW-1:0] sat_angle(input q24_t v);
    q24_t t;
    begin
      t = (v + HALF) >>> SH;
      if (t > AMAX) t = AMAX;
      if (t < AMIN) t = AMIN;
      return AW'(t);
    end
  endfunction

  logic [4:0]  state_r;
  logic        launched_r;
  logic [15:0] pn_r, mn_r;
  logic [1:0]  op_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic [23:0] ticks_r;

  logic signed [23:0]   sum_x_r, sum_y_r;
  logic [CW-1:0]        cnt_r;
  logic signed [15:0]   bias_x_r, bias_y_r;
  logic signed [AW-1:0] roll_r, pitch_r;
  logic [15:0]          var_r, gain_r, k_r;
  logic                 seeded_r;

  q24_t         mr_r, mp_r, er_r, ep_r;
  logic [31:0]  s_r, xm_r;
  logic signed [MA-1:0] t_r;

  logic         out_tvalid_r;
  logic [47:0]  out_tdata_r;
  logic         out_tuser_r;

  logic                 mul_start, div_start, sqrt_start, cor_start;
  logic                 mul_done, div_done, sqrt_done, cor_done;
  logic signed [MA-1:0] mul_a;
  logic [MB-1:0]        mul_b;
  logic signed [MP-1:0] mul_p;
  logic [31:0]          div_num, div_quo;
  logic [16:0]          div_den;
  logic [31:0]          sqrt_root;
  cxy_t                 cor_y, cor_x;
  logic signed [ZW-1:0] cor_z;
  logic                 unit_done;

  logic [16:0]        abs_ay, abs_az, pp_sum, den;
  logic [15:0]        pp;
  logic [23:0]        abs_sx, abs_sy;
  logic signed [16:0] dgx, dgy;
  logic [15:0]        bq;
  logic signed [15:0] bias_new;
  q24_t               roll_q, pitch_q, dgyro;
  q24_t               corr;
  logic signed [15:0] roll_o, pitch_o;
  logic               in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign abs_ay = ay_r[15] ? {1'b0, 16'(-ay_r)} : {1'b0, ay_r};
  assign abs_az = az_r[15] ? {1'b0, 16'(-az_r)} : {1'b0, az_r};
  assign abs_sx = sum_x_r[23] ? 24'(-sum_x_r) : 24'(sum_x_r);
  assign abs_sy = sum_y_r[23] ? 24'(-sum_y_r) : 24'(sum_y_r);
  assign dgx    = 17'(gx_r) - 17'(bias_x_r);
  assign dgy    = 17'(gy_r) - 17'(bias_y_r);
  assign pp_sum = {1'b0, var_r} + {1'b0, pn_r};
  assign pp     = pp_sum[16] ? 16'hFFFF : pp_sum[15:0];
  assign den    = {1'b0, pp} + {1'b0, mn_r};
  assign roll_q  = q24_t'(roll_r) <<< SH;
  assign pitch_q = q24_t'(pitch_r) <<< SH;
  assign dgyro  = QW'((mul_p + RND48) >>> 48);
  assign corr   = QW'((mul_p + MP'(32768)) >>> 16);
  assign bq     = div_quo[15:0];
  assign bias_new = (state_r == S_BX ? sum_x_r[23] : sum_y_r[23]) ? -signed'(bq) : signed'(bq);
  assign roll_o  = 16'((q24_t'(roll_r) >>> OSR) <<< OSL);
  assign pitch_o = 16'((q24_t'(pitch_r) >>> OSR) <<< OSL);

  assign unit_done = mul_done | div_done | sqrt_done | cor_done;

  // unit launch and operand selection
  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    cor_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = {16'b0, 16'b0};
    div_den    = '0;
    cor_y      = '0;
    cor_x      = '0;
    unique case (state_r)
      S_BX: begin
        div_start = !launched_r && (cnt_r != '0);
        div_num   = 32'(abs_sx);
        div_den   = 17'(cnt_r);
      end
      S_BY: begin
        div_start = !launched_r;
        div_num   = 32'(abs_sy);
        div_den   = 17'(cnt_r);
      end
      S_MR: begin
        cor_start = !launched_r;
        cor_y     = XYW'(ay_r) <<< 16;
        cor_x     = XYW'(az_r) <<< 16;
      end
      S_SQA: begin
        mul_start = !launched_r;
        mul_a     = MA'(signed'(abs_ay));
        mul_b     = MB'(abs_ay);
      end
      S_SQB: begin
        mul_start = !launched_r;
        mul_a     = MA'(signed'(abs_az));
        mul_b     = MB'(abs_az);
      end
      S_SQRT: sqrt_start = !launched_r;
      S_MP: begin
        cor_start = !launched_r;
        cor_y     = -(XYW'(ax_r) <<< 16);
        cor_x     = signed'({8'b0, xm_r});
      end
      S_GR1: begin
        mul_start = !launched_r;
        mul_a     = MA'(dgx);
        mul_b     = ticks_r;
      end
      S_GP1: begin
        mul_start = !launched_r;
        mul_a     = MA'(dgy);
        mul_b     = ticks_r;
      end
      S_GR2, S_GP2: begin
        mul_start = !launched_r;
        mul_a     = t_r;
        mul_b     = GYRO_SCALE;
      end
      S_KDV: begin
        div_start = !launched_r && (den != '0);
        div_num   = {pp, 16'b0} + {16'b0, den[16:1]};
        div_den   = den;
      end
      S_UR: begin
        mul_start = !launched_r;
        mul_a     = MA'(mr_r - er_r);
        mul_b     = MB'(k_r);
      end
      S_UP: begin
        mul_start = !launched_r;
        mul_a     = MA'(mp_r - ep_r);
        mul_b     = MB'(k_r);
      end
      S_UV: begin
        mul_start = !launched_r;
        mul_a     = MA'(signed'({1'b0, pp}));
        mul_b     = MB'(17'h10000 - {1'b0, k_r});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launched_r   <= 1'b0;
      pn_r         <= 16'd66;
      mn_r         <= 16'd1966;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      cnt_r        <= '0;
      bias_x_r     <= '0;
      bias_y_r     <= '0;
      roll_r       <= '0;
      pitch_r      <= '0;
      var_r        <= '0;
      gain_r       <= '0;
      k_r          <= '0;
      seeded_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_PROCESS_NOISE:     pn_r <= cfg_wdata;
          CFG_MEASUREMENT_NOISE: mn_r <= cfg_wdata;
        endcase
      end

      if (mul_start || div_start || sqrt_start || cor_start) launched_r <= 1'b1;
      else if (unit_done)                                     launched_r <= 1'b0;

      // the result stage reloads the flag itself when it hands over a new beat
      if (out_tvalid_r && out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_tuser)
              OP_CALIBRATE: begin
                if (cnt_r < CW'(CALIB_SAMPLES)) begin
                  sum_x_r <= sum_x_r + 24'(signed'(in_tdata[63:48]));
                  sum_y_r <= sum_y_r + 24'(signed'(in_tdata[79:64]));
                  cnt_r   <= cnt_r + 1'b1;
                end
                state_r <= S_OUT;
              end
              OP_SEED:   state_r <= S_BX;
              OP_FILTER: state_r <= S_MR;
              default:   state_r <= S_OUT;
            endcase
          end
        end
        S_BX: begin
          if (cnt_r == '0) begin
            bias_x_r <= '0;
            bias_y_r <= '0;
            state_r  <= S_MR;
          end else if (div_done) begin
            bias_x_r <= bias_new;
            state_r  <= S_BY;
          end
        end
        S_BY: if (div_done) begin
          bias_y_r <= bias_new;
          state_r  <= S_MR;
        end
        S_MR: if (cor_done) begin
          mr_r    <= QW'(cor_z);
          state_r <= S_SQA;
        end
        S_SQA: if (mul_done) begin
          s_r     <= 32'(mul_p);
          state_r <= S_SQB;
        end
        S_SQB: if (mul_done) begin
          s_r     <= s_r + 32'(mul_p);
          state_r <= S_SQRT;
        end
        S_SQRT: if (sqrt_done) begin
          xm_r    <= sqrt_root;
          state_r <= S_MP;
        end
        S_MP: if (cor_done) begin
          mp_r    <= QW'(cor_z);
          state_r <= (op_r == OP_SEED) ? S_SEED : S_GR1;
        end
        S_SEED: begin
          roll_r   <= sat_angle(mr_r);
          pitch_r  <= sat_angle(mp_r);
          var_r    <= '0;
          seeded_r <= 1'b1;
          state_r  <= S_OUT;
        end
        S_GR1: if (mul_done) begin
          t_r     <= MA'(mul_p);
          state_r <= S_GR2;
        end
        S_GR2: if (mul_done) begin
          er_r    <= roll_q + dgyro;
          state_r <= S_GP1;
        end
        S_GP1: if (mul_done) begin
          t_r     <= MA'(mul_p);
          state_r <= S_GP2;
        end
        S_GP2: if (mul_done) begin
          ep_r    <= pitch_q + dgyro;
          state_r <= S_KDV;
        end
        S_KDV: begin
          if (den == '0) begin
            k_r     <= '0;
            state_r <= S_UR;
          end else if (div_done) begin
            k_r     <= (div_quo > 32'd65535) ? 16'hFFFF : div_quo[15:0];
            state_r <= S_UR;
          end
        end
        S_UR: if (mul_done) begin
          roll_r  <= sat_angle(er_r + corr);
          state_r <= S_UP;
        end
        S_UP: if (mul_done) begin
          pitch_r <= sat_angle(ep_r + corr);
          state_r <= S_UV;
        end
        S_UV: if (mul_done) begin
          var_r   <= 16'((mul_p + MP'(32768)) >>> 16);
          gain_r  <= k_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // input and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      ax_r    <= in_tdata[15:0];
      ay_r    <= in_tdata[31:16];
      az_r    <= in_tdata[47:32];
      gx_r    <= in_tdata[63:48];
      gy_r    <= in_tdata[79:64];
      ticks_r <= in_tdata[103:80];
    end
    if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {gain_r, pitch_o, roll_o};
      out_tuser_r <= seeded_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  tkf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  tkf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  tkf_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .s(s_r),
    .done(sqrt_done), .root(sqrt_root)
  );

  tkf_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .y0(cor_y), .x0(cor_x),
    .done(cor_done), .z(cor_z)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    launched_r |-> !in_tready) else $error("beat taken while a unit runs");
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CALIB_SAMPLES)) else $error("calibration count overrun");
  a_seed_clears_var: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(seeded_r) |-> var_r == '0) else $error("seed left variance set");
`endif

endmodule
